@@ rtl/core/hmh_pkg.sv @@
package hmh_pkg;

    localparam int KEY_W = 32;
    localparam int PAY_W = 32;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_SET_KEY = 2'd1,
        OP_DEL_MIN = 2'd2,
        OP_REMOVE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_PRESENT = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_EMPTY   = 3'd4
    } status_t;

    // one write into the heap store
    typedef struct packed {
        logic             we;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
    } heap_wr_t;

endpackage

@@ rtl/core/hmh_heap_ram.sv @@
module hmh_heap_ram import hmh_pkg::*; #(
    parameter int SW = 7,
    parameter int IW = 8
) (
    input  logic             aclk,
    input  heap_wr_t         wr,
    input  logic [SW-1:0]    waddr,
    input  logic [IW-1:0]    wid,
    input  logic [SW-1:0]    raddr_a,
    input  logic [SW-1:0]    raddr_b,
    output logic [IW-1:0]    rid_a,
    output logic [KEY_W-1:0] rkey_a,
    output logic [PAY_W-1:0] rpay_a,
    output logic [IW-1:0]    rid_b,
    output logic [KEY_W-1:0] rkey_b,
    output logic [PAY_W-1:0] rpay_b
);

    localparam int DEPTH = 2 ** SW;
    localparam int EW    = IW + KEY_W + PAY_W;

    logic [EW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[waddr] <= {wid, wr.key, wr.pay};
        end
        {rid_a, rkey_a, rpay_a} <= mem[raddr_a];
        {rid_b, rkey_b, rpay_b} <= mem[raddr_b];
    end

endmodule

@@ rtl/core/hmh_pos_ram.sv @@
module hmh_pos_ram #(
    parameter int IW = 8,
    parameter int SW = 7
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [IW-1:0] waddr,
    input  logic [SW-1:0] wdata,
    input  logic [IW-1:0] raddr,
    output logic [SW-1:0] rdata
);

    logic [SW-1:0] mem [2 ** IW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/indexed_min_heap.sv @@
// indexed binary min-heap: entries of id, signed key and payload, smallest key at the
// root, with a position table indexed by id so that an id can be re-keyed or removed
// directly. one operation is in flight at a time and each gives exactly one result
// transaction. set key and remove pass through idle, position lookup, slot load, parent
// read and compare, closing read and result; an entry that moves walks the heap level by
// level in a read-then-compare loop around the registered heap memory. a result still
// waiting in the output register holds the sequencer for as long as m_tready is low.
// after reset the position table is swept to zero, one entry a cycle, so s_tready
// stays low until the sweep is done. ids are taken modulo ID_COUNT; out_id, out_key
// and out_payload are zero unless the operation took an entry out
module indexed_min_heap import hmh_pkg::*; #(
    parameter int CAPACITY = 64,
    parameter int ID_COUNT = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // entry_id[7:0], new_key[39:8], payload_in[71:40]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // out_id[7:0], out_key[39:8], out_payload[71:40]
    output logic [2:0]  m_tuser    // status[2:0]
);

    localparam int SW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(ID_COUNT);
    localparam logic [31:0] IDC = 32'(ID_COUNT);

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_CHK   = 12'b0000_0000_0100,
        S_LOAD  = 12'b0000_0000_1000,
        S_RS_RD = 12'b0000_0001_0000,
        S_RS_CM = 12'b0000_0010_0000,
        S_UP_RD = 12'b0000_0100_0000,
        S_UP_CM = 12'b0000_1000_0000,
        S_DN_RD = 12'b0001_0000_0000,
        S_DN_CM = 12'b0010_0000_0000,
        S_FIN   = 12'b0100_0000_0000,
        S_SPARE = 12'b1000_0000_0000
    } state_t;

    // reduce an 8-bit id modulo ID_COUNT by restoring subtraction
    function automatic logic [7:0] id_reduce(input logic [7:0] v);
        logic [31:0] r;
        r = {24'b0, v};
        for (int k = 7; k >= 0; k--) begin
            if (r >= (IDC << k)) begin
                r = r - (IDC << k);
            end
        end
        return r[7:0];
    endfunction

    // id handle widened or narrowed to the 8-bit result field
    function automatic logic [7:0] s_id_out(input logic [IW-1:0] v);
        logic [IW+7:0] e;
        e = {8'b0, v};
        return e[7:0];
    endfunction

    state_t          state_reg, state_next;
    logic [SW-1:0]   count_reg, count_next;
    logic [SW-1:0]   cur_reg, cur_next;
    logic [SW-1:0]   slot_reg, slot_next;
    logic [IW-1:0]   clr_reg, clr_next;
    op_t             op_reg, op_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [PAY_W-1:0] pay_reg, pay_next;
    logic [IW-1:0]   mv_id_reg, mv_id_next;
    logic [KEY_W-1:0] mv_key_reg, mv_key_next;
    logic [PAY_W-1:0] mv_pay_reg, mv_pay_next;
    status_t         rs_status_reg, rs_status_next;
    logic [7:0]      rs_id_reg, rs_id_next;
    logic [KEY_W-1:0] rs_key_reg, rs_key_next;
    logic [PAY_W-1:0] rs_pay_reg, rs_pay_next;
    logic            m_valid_reg, m_valid_next;
    logic [71:0]     m_data_reg, m_data_next;
    logic [2:0]      m_user_reg, m_user_next;

    // memory ports
    heap_wr_t        h_wr;
    logic [SW-1:0]   h_waddr, h_ra, h_rb;
    logic [IW-1:0]   h_wid;
    logic [IW-1:0]   a_id, b_id;
    logic [KEY_W-1:0] a_key, b_key;
    logic [PAY_W-1:0] a_pay, b_pay;
    logic            p_we;
    logic [IW-1:0]   p_waddr;
    logic [SW-1:0]   p_wdata, p_rdata;

    // incoming transaction fields
    logic [7:0]      in_red;
    logic [IW+7:0]   in_ext;
    logic [IW-1:0]   in_idx;

    // sift helpers
    logic [SW:0]     c_l, c_r, cnt_ext;
    logic            pos_vld, pick_r;
    logic [IW-1:0]   pk_id;
    logic [KEY_W-1:0] pk_key;
    logic [PAY_W-1:0] pk_pay;
    logic [IW+7:0]   a_id_ext;

    assign in_red   = id_reduce(s_tdata[7:0]);
    assign in_ext   = {{IW{1'b0}}, in_red};
    assign in_idx   = in_ext[IW-1:0];
    assign a_id_ext = {8'b0, a_id};

    assign cnt_ext = {1'b0, count_reg};
    assign c_l     = {cur_reg, 1'b0};
    assign c_r     = {cur_reg, 1'b1};
    assign pos_vld = (p_rdata != '0) && (p_rdata <= count_reg);
    assign pick_r  = (c_r <= cnt_ext) && ($signed(b_key) < $signed(a_key));
    assign pk_id   = pick_r ? b_id : a_id;
    assign pk_key  = pick_r ? b_key : a_key;
    assign pk_pay  = pick_r ? b_pay : a_pay;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    hmh_heap_ram #(.SW(SW), .IW(IW)) u_heap (
        .aclk    (aclk),
        .wr      (h_wr),
        .waddr   (h_waddr),
        .wid     (h_wid),
        .raddr_a (h_ra),
        .raddr_b (h_rb),
        .rid_a   (a_id),
        .rkey_a  (a_key),
        .rpay_a  (a_pay),
        .rid_b   (b_id),
        .rkey_b  (b_key),
        .rpay_b  (b_pay)
    );

    // position table, read address follows the incoming id so data is ready in S_CHK
    hmh_pos_ram #(.IW(IW), .SW(SW)) u_pos (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (in_idx),
        .rdata (p_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        slot_next      = slot_reg;
        clr_next       = clr_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        key_next       = key_reg;
        pay_next       = pay_reg;
        mv_id_next     = mv_id_reg;
        mv_key_next    = mv_key_reg;
        mv_pay_next    = mv_pay_reg;
        rs_status_next = rs_status_reg;
        rs_id_next     = rs_id_reg;
        rs_key_next    = rs_key_reg;
        rs_pay_next    = rs_pay_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;

        h_wr    = '{we: 1'b0, key: mv_key_reg, pay: mv_pay_reg};
        h_waddr = cur_reg;
        h_wid   = mv_id_reg;
        h_ra    = cur_reg;
        h_rb    = count_reg;
        p_we    = 1'b0;
        p_waddr = mv_id_reg;
        p_wdata = cur_reg;

        // output register drains independently of the sequencer
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                p_we    = 1'b1;
                p_waddr = clr_reg;
                p_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IW'(ID_COUNT - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                h_ra = SW'(1);
                if (s_tvalid) begin
                    op_next        = op_t'(s_tuser);
                    idx_next       = in_idx;
                    key_next       = s_tdata[39:8];
                    pay_next       = s_tdata[71:40];
                    rs_status_next = ST_OK;
                    rs_id_next     = '0;
                    rs_key_next    = '0;
                    rs_pay_next    = '0;
                    slot_next      = SW'(1);
                    unique case (op_t'(s_tuser))
                        OP_INSERT: begin
                            if (count_reg == SW'(CAPACITY)) begin
                                rs_status_next = ST_FULL;
                                state_next     = S_FIN;
                            end else begin
                                state_next = S_CHK;
                            end
                        end
                        OP_DEL_MIN: begin
                            if (count_reg == '0) begin
                                rs_status_next = ST_EMPTY;
                                state_next     = S_FIN;
                            end else begin
                                state_next = S_LOAD;
                            end
                        end
                        OP_SET_KEY, OP_REMOVE: begin
                            state_next = S_CHK;
                        end
                        default: state_next = S_CHK;
                    endcase
                end
            end
            S_CHK: begin
                h_ra = p_rdata;
                if (op_reg == OP_INSERT) begin
                    if (pos_vld) begin
                        rs_status_next = ST_PRESENT;
                        state_next     = S_FIN;
                    end else begin
                        count_next  = count_reg + 1'b1;
                        cur_next    = count_reg + 1'b1;
                        mv_id_next  = idx_reg;
                        mv_key_next = key_reg;
                        mv_pay_next = pay_reg;
                        state_next  = S_UP_RD;
                    end
                end else if (!pos_vld) begin
                    rs_status_next = ST_ABSENT;
                    state_next     = S_FIN;
                end else begin
                    slot_next  = p_rdata;
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                unique case (op_reg)
                    OP_SET_KEY: begin
                        mv_id_next  = a_id;
                        mv_key_next = key_reg;
                        mv_pay_next = a_pay;
                        cur_next    = slot_reg;
                        state_next  = S_RS_RD;
                    end
                    OP_DEL_MIN: begin
                        rs_id_next  = a_id_ext[7:0];
                        rs_key_next = a_key;
                        rs_pay_next = a_pay;
                        p_we        = 1'b1;
                        p_waddr     = a_id;
                        p_wdata     = '0;
                        count_next  = count_reg - 1'b1;
                        if (count_reg == SW'(1)) begin
                            state_next = S_FIN;
                        end else begin
                            mv_id_next  = b_id;
                            mv_key_next = b_key;
                            mv_pay_next = b_pay;
                            cur_next    = SW'(1);
                            state_next  = S_DN_RD;
                        end
                    end
                    OP_REMOVE: begin
                        rs_id_next  = s_id_out(idx_reg);
                        rs_key_next = a_key;
                        rs_pay_next = a_pay;
                        p_we        = 1'b1;
                        p_waddr     = idx_reg;
                        p_wdata     = '0;
                        count_next  = count_reg - 1'b1;
                        if (slot_reg == count_reg) begin
                            state_next = S_FIN;
                        end else begin
                            mv_id_next  = b_id;
                            mv_key_next = b_key;
                            mv_pay_next = b_pay;
                            cur_next    = slot_reg;
                            state_next  = S_RS_RD;
                        end
                    end
                    default: state_next = S_FIN;
                endcase
            end
            S_RS_RD: begin
                h_ra       = cur_reg >> 1;
                state_next = S_RS_CM;
            end
            S_RS_CM: begin
                if (cur_reg != SW'(1) && $signed(mv_key_reg) < $signed(a_key)) begin
                    h_wr    = '{we: 1'b1, key: a_key, pay: a_pay};
                    h_wid   = a_id;
                    p_we    = 1'b1;
                    p_waddr = a_id;
                    cur_next   = cur_reg >> 1;
                    state_next = S_UP_RD;
                end else begin
                    state_next = S_DN_RD;
                end
            end
            S_UP_RD: begin
                h_ra = cur_reg >> 1;
                if (cur_reg == SW'(1)) begin
                    h_wr.we    = 1'b1;
                    p_we       = 1'b1;
                    state_next = S_FIN;
                end else begin
                    state_next = S_UP_CM;
                end
            end
            S_UP_CM: begin
                if ($signed(mv_key_reg) < $signed(a_key)) begin
                    h_wr    = '{we: 1'b1, key: a_key, pay: a_pay};
                    h_wid   = a_id;
                    p_we    = 1'b1;
                    p_waddr = a_id;
                    cur_next   = cur_reg >> 1;
                    state_next = S_UP_RD;
                end else begin
                    h_wr.we    = 1'b1;
                    p_we       = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_DN_RD: begin
                h_ra = c_l[SW-1:0];
                h_rb = c_r[SW-1:0];
                if (c_l > cnt_ext) begin
                    h_wr.we    = 1'b1;
                    p_we       = 1'b1;
                    state_next = S_FIN;
                end else begin
                    state_next = S_DN_CM;
                end
            end
            S_DN_CM: begin
                if ($signed(pk_key) < $signed(mv_key_reg)) begin
                    h_wr    = '{we: 1'b1, key: pk_key, pay: pk_pay};
                    h_wid   = pk_id;
                    p_we    = 1'b1;
                    p_waddr = pk_id;
                    cur_next   = pick_r ? c_r[SW-1:0] : c_l[SW-1:0];
                    state_next = S_DN_RD;
                end else begin
                    h_wr.we    = 1'b1;
                    p_we       = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {rs_pay_reg, rs_key_reg, rs_id_reg};
                    m_user_next  = rs_status_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            count_reg   <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        slot_reg      <= slot_next;
        op_reg        <= op_next;
        idx_reg       <= idx_next;
        key_reg       <= key_next;
        pay_reg       <= pay_next;
        mv_id_reg     <= mv_id_next;
        mv_key_reg    <= mv_key_next;
        mv_pay_reg    <= mv_pay_next;
        rs_status_reg <= rs_status_next;
        rs_id_reg     <= rs_id_next;
        rs_key_reg    <= rs_key_next;
        rs_pay_reg    <= rs_pay_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

endmodule

@@ test/tb.sv @@
// scoreboard for the indexed min-heap: keeps its own copy of the heap and position
// table, predicts one result per accepted operation and checks results in order
class heap_scoreboard;
    bit [7:0]  ids   [65];
    bit [31:0] keys  [65];
    bit [31:0] pays  [65];
    bit [6:0]  where [256];
    int        count;
    bit [74:0] pending [$];   // status, out_id, out_key, out_payload
    int        errors;
    int        checked;

    function void clear();
        foreach (where[i]) where[i] = 0;
        count = 0;
    endfunction

    function bit lt(bit [31:0] a, bit [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function void put(int s, bit [7:0] id, bit [31:0] k, bit [31:0] p);
        ids[s] = id; keys[s] = k; pays[s] = p; where[id] = 7'(s);
    endfunction

    function void rise(int s);
        bit [7:0] id; bit [31:0] k, p;
        id = ids[s]; k = keys[s]; p = pays[s];
        while (s > 1 && lt(k, keys[s/2])) begin
            put(s, ids[s/2], keys[s/2], pays[s/2]);
            s = s / 2;
        end
        put(s, id, k, p);
    endfunction

    function void sink(int s);
        bit [7:0] id; bit [31:0] k, p; int c;
        id = ids[s]; k = keys[s]; p = pays[s];
        while (2*s <= count) begin
            c = 2*s;
            if (c < count && lt(keys[c+1], keys[c])) c++;
            if (!lt(keys[c], k)) break;
            put(s, ids[c], keys[c], pays[c]);
            s = c;
        end
        put(s, id, k, p);
    endfunction

    function void settle(int s);
        if (s != 1 && lt(keys[s], keys[s/2])) rise(s);
        else sink(s);
    endfunction

    function int slot_of(bit [7:0] id);
        int s;
        s = where[id];
        return (s == 0 || s > count) ? 0 : s;
    endfunction

    // accepted operation transaction
    function void note_op(hmh_pkg::op_t op, bit [7:0] id, bit [31:0] k, bit [31:0] p);
        hmh_pkg::status_t st; bit [7:0] oid; bit [31:0] ok, op2; int s, last;
        st = hmh_pkg::ST_OK; oid = 0; ok = 0; op2 = 0;
        case (op)
            hmh_pkg::OP_INSERT: begin
                if (count >= 64) st = hmh_pkg::ST_FULL;
                else if (slot_of(id) != 0) st = hmh_pkg::ST_PRESENT;
                else begin
                    count++;
                    put(count, id, k, p);
                    rise(count);
                end
            end
            hmh_pkg::OP_SET_KEY: begin
                s = slot_of(id);
                if (s == 0) st = hmh_pkg::ST_ABSENT;
                else begin
                    keys[s] = k;
                    settle(s);
                end
            end
            hmh_pkg::OP_DEL_MIN: begin
                if (count == 0) st = hmh_pkg::ST_EMPTY;
                else begin
                    oid = ids[1]; ok = keys[1]; op2 = pays[1];
                    where[oid] = 0;
                    last = count;
                    count--;
                    if (count > 0) begin
                        put(1, ids[last], keys[last], pays[last]);
                        sink(1);
                    end
                end
            end
            default: begin
                s = slot_of(id);
                if (s == 0) st = hmh_pkg::ST_ABSENT;
                else begin
                    oid = id; ok = keys[s]; op2 = pays[s];
                    where[id] = 0;
                    if (s == count) count--;
                    else begin
                        last = count;
                        put(s, ids[last], keys[last], pays[last]);
                        count--;
                        settle(s);
                    end
                end
            end
        endcase
        pending.push_back({st, oid, ok, op2});
    endfunction

    function void check_result(bit [2:0] st, bit [71:0] d);
        bit [74:0] e;
        checked++;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result status=%0d data=%h", st, d);
            return;
        end
        e = pending.pop_front();
        if (e[74:72] != st || e[71:64] != d[7:0] || e[63:32] != d[39:8]
                || e[31:0] != d[71:40]) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: exp st=%0d id=%0d key=%h pay=%h, got st=%0d id=%0d key=%h pay=%h",
                         e[74:72], e[71:64], e[63:32], e[31:0],
                         st, d[7:0], d[39:8], d[71:40]);
        end
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hmh_pkg::*;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;

    heap_scoreboard heap_sb = new();
    int send_idle_pct = 0;    // sender idle chance, in percent
    int recv_stall_pct = 0;   // receiver stall chance
    int hold_off = 0;         // cycles of forced receiver hold-off still to run
    int sent = 0;
    bit [7:0] live_ids [$];   // ids believed present, for well-formed sequences

    indexed_min_heap dut (.*);

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            heap_sb.check_result(m_tuser, m_tdata);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one operation transaction, with random idling ahead of it; s_tvalid stays high
    // after acceptance until the next transaction or an idle stretch replaces it
    task automatic send_op(op_t op, bit [7:0] id, bit [31:0] k, bit [31:0] p);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= {p, k, id};
        do @(posedge aclk); while (!s_tready);
        heap_sb.note_op(op, id, k, p);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (heap_sb.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic bit [31:0] rand_key();
        case ($urandom_range(4))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7fff_fffc + $urandom_range(3);
            2: return $urandom_range(7);     // many ties
            default: return $urandom;
        endcase
    endfunction

    function automatic bit [7:0] pick_id();
        if (live_ids.size() != 0 && $urandom_range(99) < 75)
            return live_ids[$urandom_range(live_ids.size() - 1)];
        return $urandom_range(1) ? 8'($urandom_range(79)) : 8'($urandom);
    endfunction

    task automatic random_ops(int n);
        op_t op; bit [7:0] id; int r;
        repeat (n) begin
            r = $urandom_range(99);
            // keep the heap busy: bias towards insert when small, set key when large
            if (r < (heap_sb.count < 40 ? 45 : 20)) op = OP_INSERT;
            else if (r < 65) op = OP_SET_KEY;
            else if (r < 82) op = OP_DEL_MIN;
            else op = OP_REMOVE;
            id = pick_id();
            send_op(op, id, rand_key(), $urandom);
            if (op == OP_INSERT) live_ids.push_back(id);
            if (live_ids.size() > 100) void'(live_ids.pop_front());
        end
    endtask

    initial begin
        heap_sb.clear();
        repeat (6) @(posedge aclk);
        aresetn <= 1;

        // directed: empty heap cases, extremes, ties, last-slot removal
        send_op(OP_DEL_MIN, 8'd0, 0, 0);
        send_op(OP_REMOVE, 8'd5, 0, 0);
        send_op(OP_SET_KEY, 8'd255, 0, 0);
        send_op(OP_INSERT, 8'd255, 32'h7fff_ffff, 32'hffff_ffff);
        send_op(OP_INSERT, 8'd255, 32'd1, 32'd1);
        send_op(OP_INSERT, 8'd0, 32'h8000_0000, 32'h0);
        send_op(OP_INSERT, 8'd7, 32'd5, 32'haaaa_5555);
        send_op(OP_INSERT, 8'd8, 32'd5, 32'h5555_aaaa);
        send_op(OP_INSERT, 8'd9, 32'd5, 32'h1234_5678);
        send_op(OP_SET_KEY, 8'd0, 32'h7fff_ffff, 0);
        send_op(OP_SET_KEY, 8'd255, 32'h8000_0000, 0);
        send_op(OP_REMOVE, 8'd0, 0, 0);
        send_op(OP_REMOVE, 8'd9, 0, 0);
        send_op(OP_DEL_MIN, 0, 0, 0);
        send_op(OP_DEL_MIN, 0, 0, 0);
        send_op(OP_DEL_MIN, 0, 0, 0);
        send_op(OP_DEL_MIN, 0, 0, 0);
        send_op(OP_REMOVE, 8'd8, 0, 0);
        drain();

        // fill to capacity and past it
        for (int i = 0; i < 66; i++) send_op(OP_INSERT, 8'(i * 3), $urandom, $urandom);
        for (int i = 0; i < 64; i++) live_ids.push_back(8'(i * 3));
        drain();

        random_ops(450);
        send_idle_pct = 84;
        random_ops(300);
        send_idle_pct = 0; recv_stall_pct = 84;
        random_ops(300);
        send_idle_pct = 22; recv_stall_pct = 22;
        random_ops(300);
        // sender pauses until every expected result is back
        drain();
        send_idle_pct = 0; recv_stall_pct = 0;
        // long receiver hold-off while items keep coming
        @(posedge aclk);
        hold_off <= 300;
        random_ops(200);
        random_ops(230);
        drain();

        $display("ran %0d operations through the heap, %0d results checked,", sent,
                 heap_sb.checked);
        $display("covering full and empty heaps, ties, extreme keys and back-pressure");
        if (heap_sb.errors == 0 && heap_sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/hmh_pkg.sv
rtl/core/hmh_heap_ram.sv
rtl/core/hmh_pos_ram.sv
rtl/core/indexed_min_heap.sv
test/tb.sv
